>>> hw/rtl/lazy_delete_timer_queue_core_macros.svh
// Assertion macros shared by the timer queue checkers.
`ifndef LAZY_DELETE_TIMER_QUEUE_CORE_MACROS_SVH
`define LAZY_DELETE_TIMER_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LDTQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LDTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ldtq_pkg.sv
// Types and constants shared by the timer queue modules.
package ldtq_pkg;

    localparam int OP_W        = 2;
    localparam int HANDLE_W    = 4;
    localparam int TIMEOUT_W   = 24;
    localparam int TIME_W      = 32;
    localparam int KIND_W      = 3;
    localparam int MAX_RESULTS = 16;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_EXPIRE = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED     = 3'd0,
        KIND_CANCELLED = 3'd1,
        KIND_EXPIRED   = 3'd2,
        KIND_DELAY     = 3'd3,
        KIND_NONE      = 3'd4,
        KIND_FULL      = 3'd5
    } kind_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [HANDLE_W-1:0]  handle;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [TIME_W-1:0]    now_ms;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] expired_handle;
        logic [TIME_W-1:0]   delay_ms;
        logic                queue_empty;
        logic                last;
    } result_t;

    // Contents of one queue slot.
    typedef struct packed {
        logic                occupied;
        logic                cancelled;
        logic                newest;
        logic [HANDLE_W-1:0] owner;
        logic [TIME_W-1:0]   deadline;
    } slot_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                ins;
        logic                cancel;
        logic                pop;
        logic [HANDLE_W-1:0] owner;
        logic [TIME_W-1:0]   deadline;
    } cell_cmd_t;

endpackage

>>> hw/rtl/ldtq_cell.sv
// One slot of the sorted deadline chain.
module ldtq_cell
    import ldtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  slot_t     prev_slot,
    input  logic      prev_keep,
    input  slot_t     next_slot,
    output slot_t     slot,
    output logic      keep
);

    logic                occupied_reg,  occupied_next;
    logic                cancelled_reg, cancelled_next;
    logic                newest_reg,    newest_next;
    logic [HANDLE_W-1:0] owner_reg,     owner_next;
    logic [TIME_W-1:0]   deadline_reg,  deadline_next;
    slot_t               nxt;

    assign slot = '{occupied:  occupied_reg,
                    cancelled: cancelled_reg,
                    newest:    newest_reg,
                    owner:     owner_reg,
                    deadline:  deadline_reg};

    // An occupied slot stays in place on an insert when its deadline is not later than the new one.
    assign keep = occupied_reg && (deadline_reg <= cmd.deadline);

    // Next slot contents for insert, cancel and pop.
    always_comb
    begin
        nxt = slot;
        if (cmd.ins)
        begin
            if (keep)
            begin
                nxt.newest = newest_reg && (owner_reg != cmd.owner);
            end
            else if (prev_keep)
            begin
                nxt = '{occupied: 1'b1, cancelled: 1'b0, newest: 1'b1,
                        owner: cmd.owner, deadline: cmd.deadline};
            end
            else
            begin
                nxt = prev_slot;
                nxt.newest = prev_slot.newest && (prev_slot.owner != cmd.owner);
            end
        end
        else if (cmd.cancel)
        begin
            if (occupied_reg && newest_reg && (owner_reg == cmd.owner))
            begin
                nxt.cancelled = 1'b1;
            end
        end
        else if (cmd.pop)
        begin
            nxt = next_slot;
        end
        occupied_next  = nxt.occupied;
        cancelled_next = nxt.cancelled;
        newest_next    = nxt.newest;
        owner_next     = nxt.owner;
        deadline_next  = nxt.deadline;
    end

    // Control bits are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg  <= 1'b0;
            cancelled_reg <= 1'b0;
            newest_reg    <= 1'b0;
        end
        else
        begin
            occupied_reg  <= occupied_next;
            cancelled_reg <= cancelled_next;
            newest_reg    <= newest_next;
        end
    end

    // Payload carries no reset.
    always_ff @(posedge clk)
    begin
        owner_reg    <= owner_next;
        deadline_reg <= deadline_next;
    end

endmodule

>>> hw/rtl/lazy_delete_timer_queue_core.sv
// Top level of the timer deadline queue: cell chain and request sequencer.
//
// The request channel (request_valid, request_stall, request) takes one operation:
// add, cancel, expire or query. A request is taken when request_valid is high and
// request_stall is low. The result channel (result_valid, result_stall, result)
// returns one or more results per request; the final one has last set.
// Deadlines live in a chain of QUEUE_DEPTH cells kept sorted, earliest in cell 0.
// An add or a cancel moves to an execute state in which, once the result register is
// free, the chain inserts or marks and the result is registered.
// A query first drops cancelled entries from the head, one per cycle. An expire
// drops cancelled entries and pops due timers (at most 16), one chain shift per drop
// or pop, then gives one result per cycle from the popped-handle buffer while the
// result register is free; with nothing due it returns a single result.
// The result register lets the next request be accepted while a result waits.
// While a result waits with result_stall high the sequencer holds before writing a new result.
// Reset empties the queue at once; no clearing pass is needed.
module lazy_delete_timer_queue_core
    import ldtq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 16,
    parameter int HANDLE_COUNT = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     request_valid,
    output logic     request_stall,
    input  request_t request,
    output logic     result_valid,
    input  logic     result_stall,
    output result_t  result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg;
    logic [HANDLE_W-1:0]   handle_reg;
    logic [TIME_W-1:0]     deadline_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [RES_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RES_IDX_W-1:0]  rd_reg, rd_next;
    logic [HANDLE_W-1:0]   hbuf_reg [MAX_RESULTS];
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic [HANDLE_W-1:0]   hmod_lut [2**HANDLE_W];
    slot_t                 slot_q [QUEUE_DEPTH];
    logic                  keep_q [QUEUE_DEPTH];
    cell_cmd_t             cmd;
    slot_t                 head;
    logic                  accept;
    logic                  out_free;
    logic                  full;
    logic                  due;
    logic                  room;
    logic                  push;
    logic                  emit;
    logic                  emit_last;
    result_t               res;
    logic [TIME_W:0]       sum;
    logic [TIME_W-1:0]     new_deadline;

    // Handle reduction modulo HANDLE_COUNT as a constant table.
    for (genvar g = 0; g < 2**HANDLE_W; g++)
    begin : g_hmod
        assign hmod_lut[g] = HANDLE_W'(g % HANDLE_COUNT);
    end

    // Chain of cells, each seeing its two neighbors.
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        slot_t prev_slot;
        slot_t next_slot;
        logic  prev_keep;

        if (g == 0)
        begin : g_first
            assign prev_slot = '0;
            assign prev_keep = 1'b1;
        end
        else
        begin : g_inner
            assign prev_slot = slot_q[g-1];
            assign prev_keep = keep_q[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_end
            assign next_slot = '0;
        end
        else
        begin : g_mid
            assign next_slot = slot_q[g+1];
        end

        ldtq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .prev_slot (prev_slot),
            .prev_keep (prev_keep),
            .next_slot (next_slot),
            .slot      (slot_q[g]),
            .keep      (keep_q[g])
        );
    end

    assign head          = slot_q[0];
    assign full          = slot_q[QUEUE_DEPTH-1].occupied;
    assign request_stall = (state_reg != ST_IDLE);
    assign accept        = request_valid && !request_stall;
    assign out_free      = !out_valid_reg || !result_stall;
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

    // Saturating deadline of an add.
    assign sum          = {1'b0, request.now_ms} + (TIME_W+1)'(request.timeout_ms);
    assign new_deadline = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    assign due  = head.occupied && (head.deadline <= now_reg);
    assign room = (cnt_reg < RES_CNT_W'(MAX_RESULTS));
    assign emit_last = ((RES_CNT_W'(rd_reg) + RES_CNT_W'(1)) == cnt_reg);

    // Sequencer: drives the chain command and fills the result register.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_next        = rd_reg;
        cmd            = '0;
        cmd.owner      = handle_reg;
        cmd.deadline   = deadline_reg;
        push           = 1'b0;
        emit           = 1'b0;
        res            = '0;
        res.last       = 1'b1;
        res.queue_empty = !head.occupied;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    rd_next  = '0;
                    if (op_t'(request.operation) inside {OP_ADD, OP_CANCEL})
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == OP_ADD)
                    begin
                        // Full or not, the queue holds entries after an add.
                        res.queue_empty = 1'b0;
                        if (full)
                        begin
                            res.kind = KIND_FULL;
                        end
                        else
                        begin
                            cmd.ins  = 1'b1;
                            res.kind = KIND_ADDED;
                        end
                    end
                    else
                    begin
                        cmd.cancel = 1'b1;
                        res.kind   = KIND_CANCELLED;
                    end
                end
            end
            ST_SCAN:
            begin
                if (head.occupied && head.cancelled)
                begin
                    cmd.pop = 1'b1;
                end
                else if ((op_reg == OP_EXPIRE) && due && room)
                begin
                    cmd.pop  = 1'b1;
                    push     = 1'b1;
                    cnt_next = cnt_reg + RES_CNT_W'(1);
                end
                else if ((op_reg == OP_EXPIRE) && (cnt_reg != '0))
                begin
                    state_next = ST_EMIT;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                    if ((op_reg == OP_QUERY) && head.occupied)
                    begin
                        res.kind     = KIND_DELAY;
                        res.delay_ms = (head.deadline > now_reg) ?
                                       (head.deadline - now_reg) : '0;
                    end
                    else
                    begin
                        res.kind = KIND_NONE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit               = 1'b1;
                    res.kind           = KIND_EXPIRED;
                    res.expired_handle = hbuf_reg[rd_reg];
                    res.last           = emit_last;
                    rd_next            = rd_reg + RES_IDX_W'(1);
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request fields, popped handles and the result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_t'(request.operation);
            handle_reg   <= hmod_lut[request.handle];
            deadline_reg <= new_deadline;
            now_reg      <= request.now_ms;
        end
        if (push)
        begin
            hbuf_reg[cnt_reg[RES_IDX_W-1:0]] <= head.owner;
        end
        out_reg <= out_next;
    end

endmodule

>>> hw/rtl/ldtq_checker.sv
// Port-level assertions for the timer queue, bound to the top level.
`include "lazy_delete_timer_queue_core_macros.svh"

module ldtq_checker
    import ldtq_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // Only an expire gives more than one result.
    `LDTQ_ASSERT_IMPLY(a_single_result, result_valid && (result.kind != KIND_EXPIRED), result.last, "non-expire result without last")

    // An add, taken or refused, leaves entries in the queue.
    `LDTQ_ASSERT_IMPLY(a_add_not_empty, result_valid && ((result.kind == KIND_ADDED) || (result.kind == KIND_FULL)), !result.queue_empty, "add result reports an empty queue")

    // The delay is zero unless a next delay is reported.
    `LDTQ_ASSERT_IMPLY(a_delay_zero, result_valid && (result.kind != KIND_DELAY), result.delay_ms == '0, "delay set on a result that is not a next delay")

    // The handle is zero unless a timer expired.
    `LDTQ_ASSERT_IMPLY(a_handle_zero, result_valid && (result.kind != KIND_EXPIRED), result.expired_handle == '0, "handle set on a result that is not an expiry")

    // A stalled result holds.
    `LDTQ_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

endmodule

bind lazy_delete_timer_queue_core ldtq_checker u_ldtq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
